// ===== hw/rtl/fat12ct_pkg.sv =====
package fat12ct_pkg;

  localparam int unsigned CLUSTERS_DEFAULT    = 4096;
  localparam int unsigned TABLE_BYTES_DEFAULT = 6144;

  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned CLUSTER_W = 12;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned BYTE_AW   = 13;
  localparam int unsigned OFFSET_W  = 14;

  localparam logic [CLUSTER_W-1:0] ENTRY_MARK_END    = 12'hFFF;
  localparam logic [CLUSTER_W-1:0] ENTRY_EOC_MIN     = 12'hFF8;
  localparam logic [COUNT_W-1:0]   ENTRY_COUNT_RESET = 13'd4096;
  localparam logic [COUNT_W-1:0]   FIRST_CLUSTER     = 13'd2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD  = 3'd0,
    OP_READ  = 3'd1,
    OP_GET   = 3'd2,
    OP_SET   = 3'd3,
    OP_ALLOC = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_RD_HI,
    S_ENTRY,
    S_WR_HI,
    S_BYTE,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic               we;
    logic [BYTE_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [BYTE_AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [CLUSTER_W-1:0] entry_value;
    logic [7:0]           byte_out;
    logic                 end_of_chain;
    logic                 ok;
  } result_t;

endpackage

// ===== hw/rtl/fat12ct_store.sv =====
module fat12ct_store #(
  parameter int unsigned TABLE_BYTES = 6144
) (
  input  logic                  clk_i,
  input  fat12ct_pkg::mem_req_t req_i,
  output logic [7:0]            rdata_o
);
  import fat12ct_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_BYTES);

  logic [7:0] mem [TABLE_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/fat12ct_ctrl.sv =====
module fat12ct_ctrl #(
  parameter int unsigned TABLE_BYTES = 6144
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [fat12ct_pkg::COUNT_W-1:0]       n_eff_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [fat12ct_pkg::OPCODE_W-1:0]      opcode_i,
  input  logic [fat12ct_pkg::CLUSTER_W-1:0]     cluster_i,
  input  logic [fat12ct_pkg::CLUSTER_W-1:0]     next_value_i,
  input  logic [fat12ct_pkg::BYTE_AW-1:0]       byte_addr_i,
  input  logic [7:0]                            byte_data_i,
  output fat12ct_pkg::mem_req_t                 mem_req_o,
  input  logic [7:0]                            mem_rdata_i,
  output logic                                  res_valid_o,
  input  logic                                  res_ready_i,
  output fat12ct_pkg::result_t                  res_o
);
  import fat12ct_pkg::*;

  localparam logic [OFFSET_W-1:0] TABLE_END = OFFSET_W'(TABLE_BYTES);

  state_e               state_q, state_d;
  opcode_e              op_q;
  logic [CLUSTER_W-1:0] cluster_q;
  logic [CLUSTER_W-1:0] value_q;
  logic [BYTE_AW-1:0]   baddr_q;
  logic [7:0]           bdata_q;
  logic [COUNT_W-1:0]   cur_q, cur_d;
  logic [7:0]           lo_q, lo_d;
  logic [7:0]           hi_new_q, hi_new_d;
  result_t              res_q, res_d;

  logic                 accept;
  logic [OFFSET_W-1:0]  off;
  logic [OFFSET_W-1:0]  off_p1;
  logic                 fits;
  logic                 byte_in_range;
  logic [CLUSTER_W-1:0] entry;
  logic [CLUSTER_W-1:0] wval;
  logic [7:0]           lo_new;

  assign accept = in_valid_i && (state_q == S_IDLE);

  assign off    = {1'b0, cur_q} + {2'b00, cur_q[COUNT_W-1:1]};
  assign off_p1 = off + OFFSET_W'(1);
  assign fits   = (cur_q < n_eff_i) && (off_p1 < TABLE_END);

  assign byte_in_range = {1'b0, baddr_q} < TABLE_END;

  // odd entries sit in the high 12 bits of the byte pair
  assign entry = cur_q[0] ? {mem_rdata_i, lo_q[7:4]} : {mem_rdata_i[3:0], lo_q};
  assign wval  = (op_q == OP_ALLOC) ? ENTRY_MARK_END : value_q;

  always_comb begin
    if (cur_q[0]) begin
      lo_new   = {wval[3:0], lo_q[3:0]};
      hi_new_d = wval[11:4];
    end else begin
      lo_new   = wval[7:0];
      hi_new_d = {mem_rdata_i[7:4], wval[11:8]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= opcode_e'(opcode_i);
      cluster_q <= cluster_i;
      value_q   <= next_value_i;
      baddr_q   <= byte_addr_i;
      bdata_q   <= byte_data_i;
    end
    cur_q    <= cur_d;
    lo_q     <= lo_d;
    hi_new_q <= (state_q == S_ENTRY) ? hi_new_d : hi_new_q;
    res_q    <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    lo_d        = lo_q;
    res_d       = res_q;
    mem_req_o   = '0;
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_d   = '0;
        state_d = S_EMIT;
        case (op_q)
          OP_LOAD: begin
            if (byte_in_range) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = baddr_q;
              mem_req_o.wdata = bdata_q;
              res_d.ok        = 1'b1;
            end
          end
          OP_READ: begin
            if (byte_in_range) begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = baddr_q;
              state_d         = S_BYTE;
            end
          end
          OP_GET, OP_SET: begin
            cur_d   = {1'b0, cluster_q};
            state_d = S_CHECK;
          end
          OP_ALLOC: begin
            cur_d   = FIRST_CLUSTER;
            state_d = S_CHECK;
          end
          default: begin
            state_d = S_EMIT;
          end
        endcase
      end

      S_CHECK: begin
        if (fits) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = off[BYTE_AW-1:0];
          state_d         = S_RD_HI;
        end else begin
          state_d = S_EMIT;
        end
      end

      S_RD_HI: begin
        lo_d            = mem_rdata_i;
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = off_p1[BYTE_AW-1:0];
        state_d         = S_ENTRY;
      end

      S_ENTRY: begin
        state_d = S_EMIT;
        case (op_q)
          OP_GET: begin
            res_d.entry_value  = entry;
            res_d.end_of_chain = entry >= ENTRY_EOC_MIN;
            res_d.ok           = 1'b1;
          end
          OP_SET: begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = off[BYTE_AW-1:0];
            mem_req_o.wdata = lo_new;
            res_d.ok        = 1'b1;
            state_d         = S_WR_HI;
          end
          OP_ALLOC: begin
            if (entry == '0) begin
              mem_req_o.we      = 1'b1;
              mem_req_o.waddr   = off[BYTE_AW-1:0];
              mem_req_o.wdata   = lo_new;
              res_d.entry_value = cur_q[CLUSTER_W-1:0];
              res_d.ok          = 1'b1;
              state_d           = S_WR_HI;
            end else begin
              // advance the scan
              cur_d   = cur_q + COUNT_W'(1);
              state_d = S_CHECK;
            end
          end
          default: begin
            state_d = S_EMIT;
          end
        endcase
      end

      S_WR_HI: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = off_p1[BYTE_AW-1:0];
        mem_req_o.wdata = hi_new_q;
        state_d         = S_EMIT;
      end

      S_BYTE: begin
        res_d.byte_out = mem_rdata_i;
        res_d.ok       = 1'b1;
        state_d        = S_EMIT;
      end

      S_EMIT: begin
        // hold the result until the output register is free
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

endmodule

// ===== hw/rtl/fat12_cluster_table_engine_unit.sv =====
// FAT12 cluster table engine. The table image lives in a single-port-read,
// single-port-write byte memory with a registered read; every request is
// served by a sequencer that walks that memory at most one access per cycle,
// waiting while a result is held, so one request is in work at a time while
// the previous result may still wait in the output register. Load byte,
// undefined opcodes and byte addresses out of range go straight to the
// result; read byte waits on its read; get or set of a cluster out of range
// ends at the range check. Allocate reads two bytes per cluster scanned
// from cluster 2 up to the free one, so its length follows the search. The
// byte store is not cleared: load every byte that get, set or allocate will
// touch before issuing them. The user writes entry_count through the config
// channel only while no request is in work; the block does not enforce it.
module fat12_cluster_table_engine_unit #(
  parameter int unsigned MAX_CLUSTERS = fat12ct_pkg::CLUSTERS_DEFAULT,
  parameter int unsigned TABLE_BYTES  = fat12ct_pkg::TABLE_BYTES_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fat12ct_pkg::COUNT_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fat12ct_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [fat12ct_pkg::CLUSTER_W-1:0] cluster_i,
  input  logic [fat12ct_pkg::CLUSTER_W-1:0] next_value_i,
  input  logic [fat12ct_pkg::BYTE_AW-1:0]   byte_addr_i,
  input  logic [7:0]                        byte_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [fat12ct_pkg::CLUSTER_W-1:0] entry_value_o,
  output logic [7:0]                        byte_out_o,
  output logic                              end_of_chain_o,
  output logic                              ok_o
);
  import fat12ct_pkg::*;

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_CLUSTERS);

  logic [COUNT_W-1:0] entry_count_q;
  logic [COUNT_W-1:0] n_eff;
  mem_req_t           mem_req;
  logic [7:0]         mem_rdata;
  logic               res_valid;
  logic               res_ready;
  result_t            res;
  logic               out_valid_q;
  result_t            out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= ENTRY_COUNT_RESET;
    end else if (cfg_valid_i) begin
      entry_count_q <= cfg_data_i;
    end
  end

  assign n_eff = (entry_count_q > COUNT_MAX) ? COUNT_MAX : entry_count_q;

  fat12ct_store #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(mem_rdata)
  );

  fat12ct_ctrl #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_eff_i     (n_eff),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .cluster_i   (cluster_i),
    .next_value_i(next_value_i),
    .byte_addr_i (byte_addr_i),
    .byte_data_i (byte_data_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign entry_value_o  = out_q.entry_value;
  assign byte_out_o     = out_q.byte_out;
  assign end_of_chain_o = out_q.end_of_chain;
  assign ok_o           = out_q.ok;

endmodule
